/* sv/udpbc_pkg.sv */
// Shared types, constants and helpers for the point undistortion pipeline.
// Used by every module of the block but udpbc_delay; depends on nothing.
`default_nettype none
package udpbc_pkg;

    localparam int VAL_W    = 41;
    localparam int WIDE_W   = 44;
    localparam int MAG_W    = 42;
    localparam int NUM_W    = 57;
    localparam int DEN_W    = 41;
    localparam int FRAC     = 28;
    localparam int MUL_LAT  = 4;
    localparam int RECIP_QB = 41;
    localparam int OUT_QB   = 32;
    localparam int ITER_LAT = 4 * MUL_LAT + 5 + (RECIP_QB + 1) + 1;
    localparam int PROJ_LAT = MUL_LAT + 2 + (OUT_QB + 1) + 1;

    localparam logic [2:0] CFG_INV_FOCALS = 3'd0;
    localparam logic [2:0] CFG_PRINCIPAL  = 3'd1;
    localparam logic [2:0] CFG_RADIAL     = 3'd2;
    localparam logic [2:0] CFG_TANGENTIAL = 3'd3;
    localparam logic [2:0] CFG_ROW0       = 3'd4;
    localparam logic [2:0] CFG_ROW1       = 3'd5;
    localparam logic [2:0] CFG_ROW2       = 3'd6;

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam val_t VAL_MAX = 41'sh0FFFFFFFFFF;
    localparam val_t VAL_MIN = -VAL_MAX;
    localparam val_t VAL_ONE = 41'sh00010000000;

    typedef struct packed {
        logic signed [31:0] pix_u;
        logic signed [31:0] pix_v;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               out_invalid;
    } res_t;

    typedef struct packed {
        val_t k1;
        val_t k2;
        val_t p1;
        val_t p2;
    } coef_t;

    typedef struct packed {
        val_t x;
        val_t y;
        val_t x0;
        val_t y0;
        logic bad;
    } iter_t;

    function automatic wide_t ext(input val_t v);
        return {{(WIDE_W - VAL_W){v[VAL_W-1]}}, v};
    endfunction

    function automatic val_t sx32(input logic [31:0] v);
        return {{(VAL_W - 32){v[31]}}, v};
    endfunction

    function automatic val_t sat_val(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = ext(VAL_MAX);
        lo = ext(VAL_MIN);
        if (v > hi)
            return VAL_MAX;
        else if (v < lo)
            return VAL_MIN;
        else
            return val_t'(v);
    endfunction

    function automatic logic [DEN_W-1:0] abs_val(input val_t v);
        val_t n;
        n = v[VAL_W-1] ? -v : v;
        return DEN_W'(n);
    endfunction

endpackage
`default_nettype wire

/* sv/udpbc_delay.sv */
// Fixed-length shift line for aligning side data with the datapath.
// Depends on nothing.
`default_nettype none
module udpbc_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  wire logic         clk,
    input  wire logic [W-1:0] din,
    output logic      [W-1:0] dout
);

    logic [W-1:0] sr_reg [D];

    always_ff @(posedge clk)
    begin
        sr_reg[0] <= din;
        for (int i = 1; i < D; i++)
        begin
            sr_reg[i] <= sr_reg[i-1];
        end
    end

    assign dout = sr_reg[D-1];

endmodule
`default_nettype wire

/* sv/udpbc_mul.sv */
// Pipelined fixed-point multiply: round(a*b / 2^28) half away from zero, saturated.
// Split into four 21x21 partial products. Depends on udpbc_pkg.
`default_nettype none
module udpbc_mul (
    input  wire logic              clk,
    input  wire udpbc_pkg::wide_t  a,
    input  wire udpbc_pkg::wide_t  b,
    output udpbc_pkg::val_t        p
);

    localparam int H = udpbc_pkg::MAG_W / 2;

    logic [udpbc_pkg::MAG_W-1:0] ma_reg, mb_reg;
    logic                        neg1_reg, neg2_reg, neg3_reg;
    logic [2*H-1:0]              ll_reg, lh_reg, hl_reg, hh_reg;
    logic [55:0]                 rnd_reg;
    udpbc_pkg::val_t             p_reg;
    udpbc_pkg::wide_t            abs_a, abs_b;
    logic [4*H-1:0]              sum;
    udpbc_pkg::val_t             mag;

    assign abs_a = a[udpbc_pkg::WIDE_W-1] ? -a : a;
    assign abs_b = b[udpbc_pkg::WIDE_W-1] ? -b : b;

    assign sum = (4*H)'(ll_reg)
               + ((4*H)'(lh_reg) << H)
               + ((4*H)'(hl_reg) << H)
               + ((4*H)'(hh_reg) << (2*H))
               + ((4*H)'(1) << (udpbc_pkg::FRAC - 1));

    assign mag = (rnd_reg > 56'(udpbc_pkg::VAL_MAX)) ? udpbc_pkg::VAL_MAX
                                                     : udpbc_pkg::val_t'(rnd_reg);

    always_ff @(posedge clk)
    begin
        ma_reg   <= abs_a[udpbc_pkg::MAG_W-1:0];
        mb_reg   <= abs_b[udpbc_pkg::MAG_W-1:0];
        neg1_reg <= a[udpbc_pkg::WIDE_W-1] ^ b[udpbc_pkg::WIDE_W-1];
        ll_reg   <= ma_reg[H-1:0] * mb_reg[H-1:0];
        lh_reg   <= ma_reg[H-1:0] * mb_reg[2*H-1:H];
        hl_reg   <= ma_reg[2*H-1:H] * mb_reg[H-1:0];
        hh_reg   <= ma_reg[2*H-1:H] * mb_reg[2*H-1:H];
        neg2_reg <= neg1_reg;
        rnd_reg  <= sum[udpbc_pkg::FRAC +: 56];
        neg3_reg <= neg2_reg;
        p_reg    <= neg3_reg ? -mag : mag;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

/* sv/udpbc_div_cell.sv */
// One restoring-division step: shift in a numerator bit, compare, subtract.
// Depends on udpbc_pkg.
`default_nettype none
module udpbc_div_cell #(
    parameter int QB = 32
) (
    input  wire logic                          clk,
    input  wire logic [udpbc_pkg::DEN_W-1:0]   rem_in,
    input  wire logic [QB-1:0]                 num_in,
    input  wire logic [QB-1:0]                 q_in,
    input  wire logic [udpbc_pkg::DEN_W-1:0]   d_in,
    input  wire logic                          ovf_in,
    output logic      [udpbc_pkg::DEN_W-1:0]   rem_out,
    output logic      [QB-1:0]                 num_out,
    output logic      [QB-1:0]                 q_out,
    output logic      [udpbc_pkg::DEN_W-1:0]   d_out,
    output logic                               ovf_out
);

    logic [udpbc_pkg::DEN_W:0]   t;
    logic                        ge;
    logic [udpbc_pkg::DEN_W:0]   diff;
    logic [udpbc_pkg::DEN_W-1:0] rem_reg, d_reg;
    logic [QB-1:0]               num_reg, q_reg;
    logic                        ovf_reg;

    assign t    = {rem_in, num_in[QB-1]};
    assign ge   = t >= {1'b0, d_in};
    assign diff = t - {1'b0, d_in};

    always_ff @(posedge clk)
    begin
        rem_reg <= ge ? diff[udpbc_pkg::DEN_W-1:0] : t[udpbc_pkg::DEN_W-1:0];
        num_reg <= num_in << 1;
        q_reg   <= {q_in[QB-2:0], ge};
        d_reg   <= d_in;
        ovf_reg <= ovf_in;
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign q_out   = q_reg;
    assign d_out   = d_reg;
    assign ovf_out = ovf_reg;

endmodule
`default_nettype wire

/* sv/udpbc_div.sv */
// Pipelined unsigned divider: a row of udpbc_div_cell, one quotient bit per cell.
// Flags a quotient of 2^QB or more. Depends on udpbc_pkg, udpbc_div_cell.
`default_nettype none
module udpbc_div #(
    parameter int QB = 32
) (
    input  wire logic                          clk,
    input  wire logic [udpbc_pkg::NUM_W-1:0]   n,
    input  wire logic [udpbc_pkg::DEN_W-1:0]   d,
    output logic      [QB-1:0]                 q,
    output logic                               ovf
);

    localparam int TOP_W = udpbc_pkg::NUM_W - QB;

    logic [udpbc_pkg::DEN_W-1:0] rem_w [QB+1];
    logic [QB-1:0]               num_w [QB+1];
    logic [QB-1:0]               q_w   [QB+1];
    logic [udpbc_pkg::DEN_W-1:0] d_w   [QB+1];
    logic                        ovf_w [QB+1];
    logic [udpbc_pkg::DEN_W-1:0] top;
    logic [udpbc_pkg::DEN_W-1:0] rem0_reg, d0_reg;
    logic [QB-1:0]               num0_reg;
    logic                        ovf0_reg;

    assign top = udpbc_pkg::DEN_W'(n[udpbc_pkg::NUM_W-1:QB]);

    always_ff @(posedge clk)
    begin
        rem0_reg <= top;
        num0_reg <= n[QB-1:0];
        d0_reg   <= d;
        ovf0_reg <= (top >= d);
    end

    assign rem_w[0] = rem0_reg;
    assign num_w[0] = num0_reg;
    assign q_w[0]   = '0;
    assign d_w[0]   = d0_reg;
    assign ovf_w[0] = ovf0_reg;

    for (genvar i = 0; i < QB; i++)
    begin : g_cell
        udpbc_div_cell #(.QB(QB)) u_cell (
            .clk     (clk),
            .rem_in  (rem_w[i]),
            .num_in  (num_w[i]),
            .q_in    (q_w[i]),
            .d_in    (d_w[i]),
            .ovf_in  (ovf_w[i]),
            .rem_out (rem_w[i+1]),
            .num_out (num_w[i+1]),
            .q_out   (q_w[i+1]),
            .d_out   (d_w[i+1]),
            .ovf_out (ovf_w[i+1])
        );
    end

    assign q   = q_w[QB];
    assign ovf = ovf_w[QB];

    wire unused_ok = ^{rem_w[QB], num_w[QB], d_w[QB], TOP_W[0]};

endmodule
`default_nettype wire

/* sv/udpbc_iter.sv */
// One round of distortion removal as a pipeline stage of fixed latency.
// Depends on udpbc_pkg, udpbc_mul, udpbc_div, udpbc_delay.
`default_nettype none
module udpbc_iter (
    input  wire logic              clk,
    input  wire udpbc_pkg::coef_t  coef,
    input  wire udpbc_pkg::iter_t  st_in,
    output udpbc_pkg::iter_t       st_out
);

    localparam int ML  = udpbc_pkg::MUL_LAT;
    localparam int DL  = udpbc_pkg::RECIP_QB + 1;
    localparam int VW  = udpbc_pkg::VAL_W;
    localparam int QB  = udpbc_pkg::RECIP_QB;

    udpbc_pkg::val_t xy, xs, ys;
    udpbc_pkg::val_t r2_reg, xs_reg, ys_reg, xy_reg;
    udpbc_pkg::val_t ax_reg, ay_reg, r2b_reg, xyb_reg;
    udpbc_pkg::val_t kr, q1, q2, q3, q4, r2c;
    udpbc_pkg::val_t e_reg, dx_reg, dy_reg, r2d_reg;
    udpbc_pkg::val_t ed, dx15, dy15, x0_15, y0_15;
    logic            bad16;
    udpbc_pkg::val_t den_reg, nx_reg, ny_reg;
    logic [udpbc_pkg::NUM_W-1:0] n_reg;
    logic [udpbc_pkg::DEN_W-1:0] d_reg, dmag;
    logic            neg_reg, badn_reg;
    logic [QB-1:0]   q;
    logic            ovf, neg_d;
    udpbc_pkg::val_t qs, icd_reg, nx60, ny60, x_new, y_new;
    logic            bad_out;
    udpbc_pkg::val_t x0_out, y0_out;

    udpbc_mul u_xy (.clk(clk), .a(udpbc_pkg::ext(st_in.x)), .b(udpbc_pkg::ext(st_in.y)), .p(xy));
    udpbc_mul u_xs (.clk(clk), .a(udpbc_pkg::ext(st_in.x)), .b(udpbc_pkg::ext(st_in.x)), .p(xs));
    udpbc_mul u_ys (.clk(clk), .a(udpbc_pkg::ext(st_in.y)), .b(udpbc_pkg::ext(st_in.y)), .p(ys));

    always_ff @(posedge clk)
    begin
        r2_reg  <= udpbc_pkg::sat_val(udpbc_pkg::ext(xs) + udpbc_pkg::ext(ys));
        xs_reg  <= xs;
        ys_reg  <= ys;
        xy_reg  <= xy;
        ax_reg  <= udpbc_pkg::sat_val(udpbc_pkg::ext(r2_reg) + (udpbc_pkg::ext(xs_reg) <<< 1));
        ay_reg  <= udpbc_pkg::sat_val(udpbc_pkg::ext(r2_reg) + (udpbc_pkg::ext(ys_reg) <<< 1));
        r2b_reg <= r2_reg;
        xyb_reg <= xy_reg;
    end

    udpbc_mul u_kr (.clk(clk), .a(udpbc_pkg::ext(coef.k2)), .b(udpbc_pkg::ext(r2b_reg)), .p(kr));
    udpbc_mul u_q1 (.clk(clk), .a(udpbc_pkg::ext(coef.p1)), .b(udpbc_pkg::ext(xyb_reg)), .p(q1));
    udpbc_mul u_q2 (.clk(clk), .a(udpbc_pkg::ext(coef.p2)), .b(udpbc_pkg::ext(xyb_reg)), .p(q2));
    udpbc_mul u_q3 (.clk(clk), .a(udpbc_pkg::ext(coef.p2)), .b(udpbc_pkg::ext(ax_reg)), .p(q3));
    udpbc_mul u_q4 (.clk(clk), .a(udpbc_pkg::ext(coef.p1)), .b(udpbc_pkg::ext(ay_reg)), .p(q4));
    udpbc_delay #(.W(VW), .D(ML)) u_r2d (.clk(clk), .din(r2b_reg), .dout(r2c));

    always_ff @(posedge clk)
    begin
        e_reg   <= udpbc_pkg::sat_val(udpbc_pkg::ext(kr) + udpbc_pkg::ext(coef.k1));
        dx_reg  <= udpbc_pkg::sat_val(
                       udpbc_pkg::ext(udpbc_pkg::sat_val(udpbc_pkg::ext(q1) <<< 1))
                       + udpbc_pkg::ext(q3));
        dy_reg  <= udpbc_pkg::sat_val(
                       udpbc_pkg::ext(q4)
                       + udpbc_pkg::ext(udpbc_pkg::sat_val(udpbc_pkg::ext(q2) <<< 1)));
        r2d_reg <= r2c;
    end

    udpbc_mul u_ed (.clk(clk), .a(udpbc_pkg::ext(e_reg)), .b(udpbc_pkg::ext(r2d_reg)), .p(ed));
    udpbc_delay #(.W(VW), .D(ML)) u_dxd (.clk(clk), .din(dx_reg), .dout(dx15));
    udpbc_delay #(.W(VW), .D(ML)) u_dyd (.clk(clk), .din(dy_reg), .dout(dy15));
    udpbc_delay #(.W(VW), .D(3*ML+3)) u_x0a (.clk(clk), .din(st_in.x0), .dout(x0_15));
    udpbc_delay #(.W(VW), .D(3*ML+3)) u_y0a (.clk(clk), .din(st_in.y0), .dout(y0_15));
    udpbc_delay #(.W(1), .D(3*ML+4)) u_bada (.clk(clk), .din(st_in.bad), .dout(bad16));

    assign dmag = udpbc_pkg::abs_val(den_reg);

    always_ff @(posedge clk)
    begin
        den_reg  <= udpbc_pkg::sat_val(udpbc_pkg::ext(udpbc_pkg::VAL_ONE) + udpbc_pkg::ext(ed));
        nx_reg   <= udpbc_pkg::sat_val(udpbc_pkg::ext(x0_15) - udpbc_pkg::ext(dx15));
        ny_reg   <= udpbc_pkg::sat_val(udpbc_pkg::ext(y0_15) - udpbc_pkg::ext(dy15));
        n_reg    <= (udpbc_pkg::NUM_W'(1) << (2 * udpbc_pkg::FRAC))
                  + udpbc_pkg::NUM_W'(dmag >> 1);
        d_reg    <= dmag;
        neg_reg  <= den_reg[VW-1];
        badn_reg <= bad16 | (den_reg == '0);
    end

    udpbc_div #(.QB(QB)) u_div (.clk(clk), .n(n_reg), .d(d_reg), .q(q), .ovf(ovf));
    udpbc_delay #(.W(1), .D(DL)) u_negd (.clk(clk), .din(neg_reg), .dout(neg_d));
    udpbc_delay #(.W(VW), .D(DL+2)) u_nxd (.clk(clk), .din(nx_reg), .dout(nx60));
    udpbc_delay #(.W(VW), .D(DL+2)) u_nyd (.clk(clk), .din(ny_reg), .dout(ny60));

    assign qs = (ovf || q[QB-1]) ? udpbc_pkg::VAL_MAX : udpbc_pkg::val_t'({1'b0, q[QB-2:0]});

    always_ff @(posedge clk)
    begin
        icd_reg <= neg_d ? -qs : qs;
    end

    udpbc_mul u_nx (.clk(clk), .a(udpbc_pkg::ext(nx60)), .b(udpbc_pkg::ext(icd_reg)), .p(x_new));
    udpbc_mul u_ny (.clk(clk), .a(udpbc_pkg::ext(ny60)), .b(udpbc_pkg::ext(icd_reg)), .p(y_new));
    udpbc_delay #(.W(1), .D(DL+1+ML)) u_badb (.clk(clk), .din(badn_reg), .dout(bad_out));
    udpbc_delay #(.W(VW), .D(DL+3+ML)) u_x0b (.clk(clk), .din(x0_15), .dout(x0_out));
    udpbc_delay #(.W(VW), .D(DL+3+ML)) u_y0b (.clk(clk), .din(y0_15), .dout(y0_out));

    assign st_out.x   = x_new;
    assign st_out.y   = y_new;
    assign st_out.x0  = x0_out;
    assign st_out.y0  = y0_out;
    assign st_out.bad = bad_out;

endmodule
`default_nettype wire

/* sv/udpbc_proj.sv */
// Rectify-and-project stage: 3x3 matrix, perspective divide, 32-bit saturation.
// Depends on udpbc_pkg, udpbc_mul, udpbc_div, udpbc_delay.
`default_nettype none
module udpbc_proj (
    input  wire logic              clk,
    input  wire logic [62:0]       row0,
    input  wire logic [62:0]       row1,
    input  wire logic [62:0]       row2,
    input  wire udpbc_pkg::iter_t  st_in,
    output udpbc_pkg::res_t        res
);

    localparam int ML = udpbc_pkg::MUL_LAT;
    localparam int QB = udpbc_pkg::OUT_QB;
    localparam int DL = QB + 1;

    udpbc_pkg::val_t m [3][3];
    udpbc_pkg::val_t px [3];
    udpbc_pkg::val_t py [3];
    udpbc_pkg::val_t xx_reg, yy_reg, w_reg;
    logic            bad5, bad6_reg, bad_d;
    logic [udpbc_pkg::DEN_W-1:0] wmag, d_reg;
    logic [udpbc_pkg::NUM_W-1:0] nx_reg, ny_reg;
    logic            negx_reg, negy_reg, negx_d, negy_d;
    logic [QB-1:0]   qx, qy;
    logic            ovfx, ovfy;
    udpbc_pkg::res_t res_reg;

    function automatic udpbc_pkg::val_t entry(input logic [20:0] f);
        return udpbc_pkg::val_t'($signed(f)) <<< 19;
    endfunction

    function automatic logic [31:0] sat32(input logic [QB-1:0] q, input logic ovf,
                                          input logic neg);
        if (neg)
            return (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : -q;
        else
            return (ovf || q[31]) ? 32'h7FFF_FFFF : q;
    endfunction

    always_comb
    begin
        m[0][0] = entry(row0[62:42]);
        m[0][1] = entry(row0[41:21]);
        m[0][2] = entry(row0[20:0]);
        m[1][0] = entry(row1[62:42]);
        m[1][1] = entry(row1[41:21]);
        m[1][2] = entry(row1[20:0]);
        m[2][0] = entry(row2[62:42]);
        m[2][1] = entry(row2[41:21]);
        m[2][2] = entry(row2[20:0]);
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        udpbc_mul u_mx (.clk(clk), .a(udpbc_pkg::ext(m[r][0])), .b(udpbc_pkg::ext(st_in.x)),
                        .p(px[r]));
        udpbc_mul u_my (.clk(clk), .a(udpbc_pkg::ext(m[r][1])), .b(udpbc_pkg::ext(st_in.y)),
                        .p(py[r]));
    end

    udpbc_delay #(.W(1), .D(ML+1)) u_bada (.clk(clk), .din(st_in.bad), .dout(bad5));

    always_ff @(posedge clk)
    begin
        xx_reg <= udpbc_pkg::sat_val(udpbc_pkg::ext(px[0]) + udpbc_pkg::ext(py[0])
                                     + udpbc_pkg::ext(m[0][2]));
        yy_reg <= udpbc_pkg::sat_val(udpbc_pkg::ext(px[1]) + udpbc_pkg::ext(py[1])
                                     + udpbc_pkg::ext(m[1][2]));
        w_reg  <= udpbc_pkg::sat_val(udpbc_pkg::ext(px[2]) + udpbc_pkg::ext(py[2])
                                     + udpbc_pkg::ext(m[2][2]));
    end

    assign wmag = udpbc_pkg::abs_val(w_reg);

    always_ff @(posedge clk)
    begin
        nx_reg   <= (udpbc_pkg::NUM_W'(udpbc_pkg::abs_val(xx_reg)) << 16)
                  + udpbc_pkg::NUM_W'(wmag >> 1);
        ny_reg   <= (udpbc_pkg::NUM_W'(udpbc_pkg::abs_val(yy_reg)) << 16)
                  + udpbc_pkg::NUM_W'(wmag >> 1);
        d_reg    <= wmag;
        negx_reg <= xx_reg[udpbc_pkg::VAL_W-1] ^ w_reg[udpbc_pkg::VAL_W-1];
        negy_reg <= yy_reg[udpbc_pkg::VAL_W-1] ^ w_reg[udpbc_pkg::VAL_W-1];
        bad6_reg <= bad5 | (w_reg == '0);
    end

    udpbc_div #(.QB(QB)) u_divx (.clk(clk), .n(nx_reg), .d(d_reg), .q(qx), .ovf(ovfx));
    udpbc_div #(.QB(QB)) u_divy (.clk(clk), .n(ny_reg), .d(d_reg), .q(qy), .ovf(ovfy));
    udpbc_delay #(.W(1), .D(DL)) u_negx (.clk(clk), .din(negx_reg), .dout(negx_d));
    udpbc_delay #(.W(1), .D(DL)) u_negy (.clk(clk), .din(negy_reg), .dout(negy_d));
    udpbc_delay #(.W(1), .D(DL)) u_badb (.clk(clk), .din(bad6_reg), .dout(bad_d));

    always_ff @(posedge clk)
    begin
        res_reg.out_x       <= bad_d ? '0 : sat32(qx, ovfx, negx_d);
        res_reg.out_y       <= bad_d ? '0 : sat32(qy, ovfy, negy_d);
        res_reg.out_invalid <= bad_d;
    end

    assign res = res_reg;

endmodule
`default_nettype wire

/* sv/undistort_point_brown_conrady.sv */
// From start to done a point passes ITERATIONS rounds, each through the 41-cell
// reciprocal divider and four multiplier passes, and then the projection stage.
// Throughput: one point per cycle; busy stays low, results cannot be held off.
// Reset: async, active low; clears the done pipeline and loads default calibration.
// Depends on udpbc_pkg, udpbc_mul, udpbc_iter, udpbc_proj.
`default_nettype none
module undistort_point_brown_conrady #(
    parameter int ITERATIONS = 5
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire udpbc_pkg::req_t  req,
    output logic                  done,
    output udpbc_pkg::res_t       result,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [63:0]      cfg_data
);

    localparam int LAT = 1 + udpbc_pkg::MUL_LAT + ITERATIONS * udpbc_pkg::ITER_LAT
                       + udpbc_pkg::PROJ_LAT;

    logic [63:0] focal_reg, pp_reg, rad_reg, tan_reg;
    logic [62:0] row0_reg, row1_reg, row2_reg;
    logic [LAT-1:0] vld_reg;
    logic signed [32:0] du_reg, dv_reg;
    logic        accept;
    udpbc_pkg::val_t  x0, y0;
    udpbc_pkg::coef_t coef;
    udpbc_pkg::iter_t st [ITERATIONS+1];

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg <= 64'h4000_0000_4000_0000;
            pp_reg    <= '0;
            rad_reg   <= '0;
            tan_reg   <= '0;
            row0_reg  <= 63'h0008_0000_0000_0000;
            row1_reg  <= 63'h0000_0000_4000_0000;
            row2_reg  <= 63'h0000_0000_0000_0200;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                udpbc_pkg::CFG_INV_FOCALS: focal_reg <= cfg_data;
                udpbc_pkg::CFG_PRINCIPAL:  pp_reg    <= cfg_data;
                udpbc_pkg::CFG_RADIAL:     rad_reg   <= cfg_data;
                udpbc_pkg::CFG_TANGENTIAL: tan_reg   <= cfg_data;
                udpbc_pkg::CFG_ROW0:       row0_reg  <= cfg_data[62:0];
                udpbc_pkg::CFG_ROW1:       row1_reg  <= cfg_data[62:0];
                udpbc_pkg::CFG_ROW2:       row2_reg  <= cfg_data[62:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], accept};
    end

    // subtract principal point
    always_ff @(posedge clk)
    begin
        du_reg <= $signed({req.pix_u[31], req.pix_u}) - $signed({pp_reg[63], pp_reg[63:32]});
        dv_reg <= $signed({req.pix_v[31], req.pix_v}) - $signed({pp_reg[31], pp_reg[31:0]});
    end

    udpbc_mul u_nu (
        .clk (clk),
        .a   (udpbc_pkg::wide_t'($signed({du_reg, 10'b0}))),
        .b   (udpbc_pkg::wide_t'($signed({1'b0, focal_reg[63:32]}))),
        .p   (x0)
    );
    udpbc_mul u_nv (
        .clk (clk),
        .a   (udpbc_pkg::wide_t'($signed({dv_reg, 10'b0}))),
        .b   (udpbc_pkg::wide_t'($signed({1'b0, focal_reg[31:0]}))),
        .p   (y0)
    );

    assign coef.k1 = udpbc_pkg::sx32(rad_reg[63:32]);
    assign coef.k2 = udpbc_pkg::sx32(rad_reg[31:0]);
    assign coef.p1 = udpbc_pkg::sx32(tan_reg[63:32]);
    assign coef.p2 = udpbc_pkg::sx32(tan_reg[31:0]);

    assign st[0].x   = x0;
    assign st[0].y   = y0;
    assign st[0].x0  = x0;
    assign st[0].y0  = y0;
    assign st[0].bad = 1'b0;

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_iter
        udpbc_iter u_iter (
            .clk    (clk),
            .coef   (coef),
            .st_in  (st[i]),
            .st_out (st[i+1])
        );
    end

    udpbc_proj u_proj (
        .clk   (clk),
        .row0  (row0_reg),
        .row1  (row1_reg),
        .row2  (row2_reg),
        .st_in (st[ITERATIONS]),
        .res   (result)
    );

    assign done = vld_reg[LAT-1];

endmodule
`default_nettype wire
